[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[src/slu_pkg.sv]
// ----------------------------------------------------------------------------
// String literal unescaper package
// Types, codes and the escape table shared by the unescaper modules.
// ----------------------------------------------------------------------------
package slu_pkg;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_ESCAPE = 2'd1;
	localparam logic [1:0] STATUS_UTF8   = 2'd2;

	localparam logic [7:0] CHAR_BACKQUOTE = 8'h60;
	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic       after_backslash;
		logic [1:0] utf8_bytes_left;
		logic       raw_mode;
		logic       at_first_byte;
		logic [1:0] error_code;
	} state_t;

	localparam state_t STATE_RESET = '{
		after_backslash: 1'b0,
		utf8_bytes_left: 2'd0,
		raw_mode:        1'b0,
		at_first_byte:   1'b1,
		error_code:      STATUS_OK
	};

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic [1:0] status;
		logic       end_of_string;
	} result_t;

	// Escape letter lookup: bit 8 is the hit flag, bits 7:0 the decoded byte.
	function automatic logic [8:0] escape_lookup(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h6E:   r = {1'b1, 8'h0A}; // n
			8'h62:   r = {1'b1, 8'h08}; // b
			8'h61:   r = {1'b1, 8'h07}; // a
			8'h72:   r = {1'b1, 8'h0D}; // r
			8'h27:   r = {1'b1, 8'h27}; // single quote
			8'h5C:   r = {1'b1, 8'h5C}; // backslash
			8'h60:   r = {1'b1, 8'h60}; // backquote
			8'h22:   r = {1'b1, 8'h22}; // double quote
			8'h74:   r = {1'b1, 8'h09}; // t
			8'h30:   r = {1'b1, 8'h00}; // digit zero
			default: r = {1'b0, 8'h00};
		endcase
		return r;
	endfunction

endpackage

[src/slu_if.sv]
// ----------------------------------------------------------------------------
// String literal unescaper channels
// Valid/ready channels for input bytes and for decoded results.
// ----------------------------------------------------------------------------
interface slu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface slu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic [1:0] status;
	logic       end_of_string;

	modport source (output valid, output out_byte, output has_byte, output status,
		output end_of_string, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input status,
		input end_of_string, output ready);
endinterface

[src/string_literal_unescaper.sv]
// Path: an accepted byte is held in the input stage, decoded combinationally
// once the queue has room, and its results are registered in the result queue.
// Throughput: one byte per cycle while the queue can take two results, set by the
// one-result-per-cycle output port; a raw-mode backslash pair yields two results.
// Reset: arst_n clears the decoder state to the start of a new literal and
// empties the input stage and the result queue.
// ----------------------------------------------------------------------------
// String literal unescaper
// Decodes escapes and checks UTF-8 framing in a byte stream of string literals.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module string_literal_unescaper (
	input  logic           clk,
	input  logic           arst_n,
	slu_in_if.sink         bytes,
	slu_out_if.source      results
);

	// Input stage: one byte held until the decoder has room to take it.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Decoder state carried from byte to byte within a literal.
	slu_pkg::state_t st_q;
	slu_pkg::state_t st_next;

	slu_pkg::result_t res0;
	slu_pkg::result_t res1;
	logic [1:0]       res_cnt;

	// Result queue: a byte may produce two results, while the output side
	// drains at most one per cycle, so results are buffered in a short queue.
	slu_pkg::result_t fifo_q [slu_pkg::FIFO_DEPTH];
	slu_pkg::ptr_t    head_q;
	slu_pkg::ptr_t    tail_q;
	slu_pkg::cnt_t    count_q;

	logic       in_accept;
	logic       pop;
	logic       process;
	logic [1:0] push_cnt;

	// The decoder only advances when the queue can absorb the worst case of
	// two results, independent of whether a result leaves in the same cycle.
	assign process   = valid_s1 &&
		(count_q <= slu_pkg::cnt_t'(slu_pkg::FIFO_DEPTH - 2));
	assign bytes.ready = !valid_s1 || process;
	assign in_accept = bytes.valid && bytes.ready;
	assign pop       = results.valid && results.ready;
	assign push_cnt  = process ? res_cnt : 2'd0;

	slu_decode u_decode (
		.st      (st_q),
		.in_byte (byte_s1),
		.is_last (last_s1),
		.st_next (st_next),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= bytes.in_byte;
			last_s1 <= bytes.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= slu_pkg::STATE_RESET;
		end else if (process) begin
			st_q <= st_next;
		end
	end

	// Queue payload: the first result goes to the tail, a second one right after.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			fifo_q[tail_q] <= res0;
		end
		if (push_cnt == 2'd2) begin
			fifo_q[slu_pkg::ptr_t'(tail_q + 1'b1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= slu_pkg::ptr_t'(head_q + 1'b1);
			end
			tail_q  <= slu_pkg::ptr_t'(tail_q + slu_pkg::ptr_t'(push_cnt));
			count_q <= count_q + slu_pkg::cnt_t'(push_cnt) - slu_pkg::cnt_t'(pop);
		end
	end

	assign results.valid         = (count_q != '0);
	assign results.out_byte      = fifo_q[head_q].out_byte;
	assign results.has_byte      = fifo_q[head_q].has_byte;
	assign results.status        = fifo_q[head_q].status;
	assign results.end_of_string = fifo_q[head_q].end_of_string;

	// The queue never holds more entries than it has slots.
	`ASSERT_ALWAYS(a_fifo_bound, count_q <= slu_pkg::cnt_t'(slu_pkg::FIFO_DEPTH),
		"result queue overflow")

	// A pending escape and a pending UTF-8 continuation exclude each other.
	`ASSERT_IMPLY(a_state_excl, st_q.utf8_bytes_left != 2'd0, !st_q.after_backslash,
		"backslash pending inside a UTF-8 sequence")

	// A failed literal stays silent until its last byte.
	`ASSERT_IMPLY(a_err_silent,
		process && st_q.error_code != slu_pkg::STATUS_OK && !last_s1, push_cnt == 2'd0,
		"result produced after an error")

	// Decoding the last byte returns the decoder to the start of a literal.
	`ASSERT_NEXT(a_last_reset, process && last_s1, st_q == slu_pkg::STATE_RESET,
		"state not cleared after the last byte")

endmodule

[src/slu_decode.sv]
// ----------------------------------------------------------------------------
// String literal unescaper decode step
// Combinational decode of one byte: next state and up to two results.
// ----------------------------------------------------------------------------
module slu_decode (
	input  slu_pkg::state_t  st,
	input  logic [7:0]       in_byte,
	input  logic             is_last,
	output slu_pkg::state_t  st_next,
	output slu_pkg::result_t res0,
	output slu_pkg::result_t res1,
	output logic [1:0]       res_cnt
);

	always_comb begin
		logic             raw;
		logic             pre;
		logic             main_emit;
		logic             plain;
		logic [7:0]       main_byte;
		logic [1:0]       err;
		logic [8:0]       esc;
		logic [1:0]       left_n;
		slu_pkg::result_t second;

		st_next   = st;
		res0      = '0;
		res1      = '0;
		res_cnt   = 2'd0;
		raw       = st.raw_mode;
		pre       = 1'b0;
		main_emit = 1'b0;
		plain     = 1'b1;
		main_byte = in_byte;
		err       = slu_pkg::STATUS_OK;
		esc       = slu_pkg::escape_lookup(in_byte);
		left_n    = st.utf8_bytes_left - 2'd1;
		second    = '0;

		if (st.error_code != slu_pkg::STATUS_OK) begin
			// The literal already failed: stay silent until its last byte.
			if (is_last) begin
				res0.status        = st.error_code;
				res0.end_of_string = 1'b1;
				res_cnt            = 2'd1;
				st_next            = slu_pkg::STATE_RESET;
			end
		end else begin
			if (st.at_first_byte) begin
				raw = (in_byte == slu_pkg::CHAR_BACKQUOTE);
			end
			st_next.raw_mode      = raw;
			st_next.at_first_byte = 1'b0;

			if (st.utf8_bytes_left != 2'd0) begin
				st_next.utf8_bytes_left = left_n;
				if (is_last && left_n != 2'd0) begin
					err = slu_pkg::STATUS_UTF8;
				end else begin
					main_emit = 1'b1;
				end
			end else begin
				if (st.after_backslash) begin
					st_next.after_backslash = 1'b0;
					if (raw && in_byte != slu_pkg::CHAR_BACKQUOTE) begin
						pre = 1'b1;
					end else begin
						plain = 1'b0;
						if (esc[8]) begin
							main_emit = 1'b1;
							main_byte = esc[7:0];
						end else begin
							err = slu_pkg::STATUS_ESCAPE;
						end
					end
				end
				if (plain) begin
					if (in_byte[7]) begin
						if (in_byte[6:5] == 2'b10) begin
							left_n = 2'd1;
						end else if (in_byte[6:4] == 3'b110) begin
							left_n = 2'd2;
						end else if (in_byte[6:3] == 4'b1110) begin
							left_n = 2'd3;
						end else begin
							left_n = 2'd0;
						end
						if (left_n == 2'd0 || is_last) begin
							err = slu_pkg::STATUS_UTF8;
						end else begin
							main_emit               = 1'b1;
							st_next.utf8_bytes_left = left_n;
						end
					end else if (in_byte == slu_pkg::CHAR_BACKSLASH) begin
						if (is_last) begin
							err = slu_pkg::STATUS_ESCAPE;
						end else begin
							st_next.after_backslash = 1'b1;
						end
					end else begin
						main_emit = 1'b1;
					end
				end
			end

			st_next.error_code = err;

			if (main_emit) begin
				second.out_byte = main_byte;
				second.has_byte = 1'b1;
			end else begin
				second.status = err;
			end

			if (pre) begin
				res0.out_byte = slu_pkg::CHAR_BACKSLASH;
				res0.has_byte = 1'b1;
				res1          = second;
			end else begin
				res0 = second;
			end
			res_cnt = {1'b0, pre} + {1'b0, main_emit || (err != slu_pkg::STATUS_OK)};

			if (is_last) begin
				// An empty step on the last byte still closes the literal.
				if (res_cnt == 2'd0) begin
					res0    = '0;
					res_cnt = 2'd1;
				end
				if (res_cnt == 2'd2) begin
					res1.end_of_string = 1'b1;
				end else begin
					res0.end_of_string = 1'b1;
				end
				st_next = slu_pkg::STATE_RESET;
			end
		end
	end

endmodule

[bench/tb_string_literal_unescaper.sv]
// ----------------------------------------------------------------------------
// String literal unescaper testbench
// Drives string literals, byte by byte, into the unescaper with random idle
// cycles on both channels. A behavioral decoder inside the bench predicts
// every result, and a monitor compares each result the block returns against
// the oldest prediction. Directed literals come first, then random literals.
// ----------------------------------------------------------------------------
module tb_string_literal_unescaper;

	// Input bytes to send over the whole run, directed literals included.
	localparam int ITEM_TARGET  = 1550;
	// Cycles to wait after the last expected result. A result passes the input
	// stage and the result queue before it leaves, so this leaves ample margin.
	localparam int DRAIN_CYCLES = 8;
	// Hard stop for the whole run.
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_GAP      = 11;

	localparam logic [7:0] CHAR_QUOTE = 8'h22;
	// The ten escape letters: n b a r ' \ ` " t 0.
	localparam logic [79:0] ESCAPE_LETTERS = {8'h6E, 8'h62, 8'h61, 8'h72, 8'h27,
		8'h5C, 8'h60, 8'h22, 8'h74, 8'h30};

	logic clk;
	logic arst_n;

	slu_in_if  bytes_if ();
	slu_out_if results_if ();

	string_literal_unescaper i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_if),
		.results (results_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------------
	// Decoder state of the bench. It mirrors the block's state at the start of
	// a literal and is brought back there after every byte marked as last.
	// ------------------------------------------------------------------------
	logic       pending_backslash = 1'b0;
	int         continuation_left = 0;
	logic       raw_literal       = 1'b0;
	logic       literal_start     = 1'b1;
	logic [1:0] literal_fault     = slu_pkg::STATUS_OK;

	// Results the decoder has predicted and the block has not yet returned.
	slu_pkg::result_t expected_results[$];

	// Bytes of the literal that is about to be sent.
	logic [7:0] literal_bytes[$];

	// Idle controls. When busy is clear the side runs without any gaps.
	bit src_busy  = 1'b1;
	bit sink_busy = 1'b1;

	int cycle_count     = 0;
	int bytes_sent      = 0;
	int bytes_decoded   = 0;
	int literals_sent   = 0;
	int raw_literals    = 0;
	int results_checked = 0;
	int escape_errors   = 0;
	int utf8_errors     = 0;
	int mismatch_count  = 0;

	// ------------------------------------------------------------------------
	// Decoder functions
	// ------------------------------------------------------------------------

	// Maps an escape letter to the byte it stands for. Returns 0 for a byte
	// that is not one of the ten escape letters.
	function automatic logic escape_byte(input logic [7:0] letter, output logic [7:0] value);
		escape_byte = 1'b1;
		case (letter)
			8'h6E:   value = 8'h0A; // newline
			8'h62:   value = 8'h08; // backspace
			8'h61:   value = 8'h07; // bell
			8'h72:   value = 8'h0D; // carriage return
			8'h27:   value = 8'h27; // single quote
			8'h5C:   value = 8'h5C; // backslash
			8'h60:   value = 8'h60; // backquote
			8'h22:   value = 8'h22; // double quote
			8'h74:   value = 8'h09; // tab
			8'h30:   value = 8'h00; // NUL
			default: begin
				value       = 8'h00;
				escape_byte = 1'b0;
			end
		endcase
	endfunction

	// Length of the UTF-8 sequence that a lead byte opens, 0 for a bad lead.
	function automatic int utf8_length(input logic [7:0] lead);
		if (lead[7:5] == 3'b110)
			return 2;
		if (lead[7:4] == 4'b1110)
			return 3;
		if (lead[7:3] == 5'b11110)
			return 4;
		return 0;
	endfunction

	task automatic expect_result(input logic [7:0] value, input logic has, input logic [1:0] st);
		slu_pkg::result_t r;
		r.out_byte      = has ? value : 8'h00;
		r.has_byte      = has;
		r.status        = st;
		r.end_of_string = 1'b0;
		expected_results.push_back(r);
	endtask

	// Works out the results of one accepted byte and queues them.
	task automatic predict_byte(input logic [7:0] b, input logic final_byte);
		logic [1:0]       fault;
		logic             plain;
		logic [7:0]       ctrl;
		int               seq_len;
		int               produced;
		slu_pkg::result_t tail;

		fault    = slu_pkg::STATUS_OK;
		produced = expected_results.size();

		// Once a literal has failed, its remaining bytes are dropped until the
		// last one, which reports the stored error below.
		if (literal_fault == slu_pkg::STATUS_OK) begin
			bytes_decoded++;
			if (literal_start) begin
				raw_literal   = (b == slu_pkg::CHAR_BACKQUOTE);
				literal_start = 1'b0;
			end

			if (continuation_left > 0) begin
				// Continuation bytes pass unchecked, unless the literal ends
				// before the sequence is complete.
				continuation_left--;
				if (final_byte && continuation_left > 0)
					fault = slu_pkg::STATUS_UTF8;
				else
					expect_result(b, 1'b1, slu_pkg::STATUS_OK);
			end else begin
				plain = 1'b1;
				if (pending_backslash) begin
					pending_backslash = 1'b0;
					if (raw_literal && b != slu_pkg::CHAR_BACKQUOTE) begin
						// Raw text keeps the backslash, and the current byte is
						// then decoded on its own.
						expect_result(slu_pkg::CHAR_BACKSLASH, 1'b1, slu_pkg::STATUS_OK);
					end else begin
						plain = 1'b0;
						if (escape_byte(b, ctrl))
							expect_result(ctrl, 1'b1, slu_pkg::STATUS_OK);
						else
							fault = slu_pkg::STATUS_ESCAPE;
					end
				end
				if (plain) begin
					if (b[7]) begin
						seq_len = utf8_length(b);
						if (seq_len == 0 || final_byte) begin
							fault = slu_pkg::STATUS_UTF8;
						end else begin
							expect_result(b, 1'b1, slu_pkg::STATUS_OK);
							continuation_left = seq_len - 1;
						end
					end else if (b == slu_pkg::CHAR_BACKSLASH) begin
						// A backslash at the end has nothing to escape.
						if (final_byte)
							fault = slu_pkg::STATUS_ESCAPE;
						else
							pending_backslash = 1'b1;
					end else begin
						expect_result(b, 1'b1, slu_pkg::STATUS_OK);
					end
				end
			end

			if (fault != slu_pkg::STATUS_OK) begin
				literal_fault = fault;
				expect_result(8'h00, 1'b0, fault);
			end
		end

		if (final_byte) begin
			if (expected_results.size() == produced)
				expect_result(8'h00, 1'b0, literal_fault);
			// The last result of the final byte carries the end flag.
			tail = expected_results[expected_results.size() - 1];
			tail.end_of_string = 1'b1;
			expected_results[expected_results.size() - 1] = tail;
			pending_backslash = 1'b0;
			continuation_left = 0;
			raw_literal       = 1'b0;
			literal_start     = 1'b1;
			literal_fault     = slu_pkg::STATUS_OK;
		end
	endtask

	// Compares one returned result with the oldest prediction.
	task automatic check_result(input slu_pkg::result_t got);
		slu_pkg::result_t want;

		results_checked++;
		if (!got.has_byte && got.status == slu_pkg::STATUS_ESCAPE)
			escape_errors++;
		if (!got.has_byte && got.status == slu_pkg::STATUS_UTF8)
			utf8_errors++;

		if (expected_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$write("Result %0d arrived with nothing pending: ", results_checked);
				$display("byte %02h has %0b status %0d end %0b",
					got.out_byte, got.has_byte, got.status, got.end_of_string);
			end
		end else begin
			want = expected_results.pop_front();
			if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
					got.status !== want.status || got.end_of_string !== want.end_of_string) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$write("Result %0d differs: expected byte %02h has %0b status %0d end %0b,",
						results_checked, want.out_byte, want.has_byte, want.status,
						want.end_of_string);
					$display(" got byte %02h has %0b status %0d end %0b",
						got.out_byte, got.has_byte, got.status, got.end_of_string);
				end
			end
		end
	endtask

	// Monitor. Values are read at the rising edge, before any nonblocking
	// update of that edge, so a transaction is seen exactly when it happens.
	always @(posedge clk) begin
		if (arst_n) begin
			if (bytes_if.valid && bytes_if.ready)
				predict_byte(bytes_if.in_byte, bytes_if.is_last);
			if (results_if.valid && results_if.ready)
				check_result({results_if.out_byte, results_if.has_byte, results_if.status,
					results_if.end_of_string});
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still pending",
				cycle_count, expected_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: after each transaction it may hold ready low for a random
	// number of cycles. Ready stays high across back-to-back transactions.
	initial begin : result_sink
		int stall;

		results_if.ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = sink_busy ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				results_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!results_if.valid);
		end
	end

	// ------------------------------------------------------------------------
	// Byte side
	// ------------------------------------------------------------------------

	// Offers one byte, after a random gap, and returns at the edge of its
	// transaction. Valid stays high so the next byte can follow at once.
	task automatic send_byte(input logic [7:0] b, input logic final_byte);
		int gap;

		gap = src_busy ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			bytes_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_if.valid   <= 1'b1;
		bytes_if.in_byte <= b;
		bytes_if.is_last <= final_byte;
		do
			@(posedge clk);
		while (!bytes_if.ready);
		bytes_sent++;
	endtask

	task automatic send_literal();
		literals_sent++;
		if (literal_bytes[0] == slu_pkg::CHAR_BACKQUOTE)
			raw_literals++;
		foreach (literal_bytes[i])
			send_byte(literal_bytes[i], i == literal_bytes.size() - 1);
	endtask

	// Stops sending and waits until every predicted result has come back.
	task automatic wait_for_drain();
		bytes_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	function automatic logic [7:0] random_lead(input int seq_len);
		logic [7:0] c;

		c = 8'($urandom_range(0, 255));
		case (seq_len)
			2:       c[7:5] = 3'b110;
			3:       c[7:4] = 4'b1110;
			default: c[7:3] = 5'b11110;
		endcase
		return c;
	endfunction

	// Mostly proper continuation bytes; now and then any byte, since the
	// block does not look at them.
	function automatic logic [7:0] random_continuation();
		if ($urandom_range(0, 7) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h80, 8'hBF));
	endfunction

	// Appends one piece of literal text. Broken pieces include unknown
	// escapes and bad lead bytes.
	task automatic add_segment(input bit raw_text, input bit broken);
		int         pick;
		int         seq_len;
		int         idx;
		logic [7:0] c;

		pick = $urandom_range(0, broken ? 5 : 3);
		if (pick == 3 && !raw_text)
			pick = 1;
		case (pick)
			0: begin
				repeat ($urandom_range(1, 4)) begin
					c = 8'($urandom_range(0, 127));
					if (c == slu_pkg::CHAR_BACKSLASH)
						c = 8'h41;
					literal_bytes.push_back(c);
				end
			end
			1: begin
				idx = $urandom_range(0, 9);
				literal_bytes.push_back(slu_pkg::CHAR_BACKSLASH);
				literal_bytes.push_back(ESCAPE_LETTERS[8*idx +: 8]);
			end
			2: begin
				seq_len = $urandom_range(2, 4);
				literal_bytes.push_back(random_lead(seq_len));
				repeat (seq_len - 1)
					literal_bytes.push_back(random_continuation());
			end
			3: begin
				// Raw text: a backslash that escapes nothing.
				c = 8'($urandom_range(8'h20, 8'h7E));
				if (c == slu_pkg::CHAR_BACKQUOTE || c == slu_pkg::CHAR_BACKSLASH)
					c = 8'h7A;
				literal_bytes.push_back(slu_pkg::CHAR_BACKSLASH);
				literal_bytes.push_back(c);
			end
			4: begin
				literal_bytes.push_back(slu_pkg::CHAR_BACKSLASH);
				literal_bytes.push_back(8'($urandom_range(0, 255)));
			end
			default: begin
				if ($urandom_range(0, 1))
					literal_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
				else
					literal_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
			end
		endcase
	endtask

	// Builds one random literal: mostly well formed, some with broken text,
	// some cut off in the middle of a sequence, and some pure noise.
	task automatic build_random_literal();
		int kind;
		int seq_len;
		bit raw_text;

		literal_bytes.delete();
		kind     = $urandom_range(0, 9);
		raw_text = ($urandom_range(0, 2) == 0);
		if (kind == 0) begin
			repeat ($urandom_range(1, 10))
				literal_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			literal_bytes.push_back(raw_text ? slu_pkg::CHAR_BACKQUOTE : CHAR_QUOTE);
			repeat ($urandom_range(0, 8))
				add_segment(raw_text, kind == 1);
			if (kind == 2) begin
				if ($urandom_range(0, 1)) begin
					literal_bytes.push_back(slu_pkg::CHAR_BACKSLASH);
				end else begin
					seq_len = $urandom_range(3, 4);
					literal_bytes.push_back(random_lead(seq_len));
					repeat ($urandom_range(0, seq_len - 2))
						literal_bytes.push_back(random_continuation());
				end
			end else begin
				literal_bytes.push_back(raw_text ? slu_pkg::CHAR_BACKQUOTE : CHAR_QUOTE);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Lowest and highest plain bytes pass through unchanged.
	task automatic test_plain_bytes();
		literal_bytes = '{8'h00, 8'h7F, CHAR_QUOTE};
		send_literal();
	endtask

	// Known escapes decode; an unknown escape fails the literal, and the
	// bytes after it are dropped until the end.
	task automatic test_escapes();
		literal_bytes = '{slu_pkg::CHAR_BACKSLASH, 8'h6E, slu_pkg::CHAR_BACKSLASH,
			slu_pkg::CHAR_BACKQUOTE, slu_pkg::CHAR_BACKSLASH, 8'h71, CHAR_QUOTE};
		send_literal();
	endtask

	// Raw text: backslash-backquote decodes, a backslash before another byte
	// gives two results in one step, and a trailing backslash is an error.
	task automatic test_raw_mode();
		literal_bytes = '{slu_pkg::CHAR_BACKQUOTE, slu_pkg::CHAR_BACKSLASH,
			slu_pkg::CHAR_BACKQUOTE, slu_pkg::CHAR_BACKSLASH, 8'h61,
			slu_pkg::CHAR_BACKSLASH};
		send_literal();
	endtask

	// A complete two-byte sequence, then a three-byte one cut off by the end,
	// then a bad lead byte, and a good lead byte as the final byte.
	task automatic test_utf8();
		literal_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82};
		send_literal();
		literal_bytes = '{8'hFF};
		send_literal();
		literal_bytes = '{8'hC0};
		send_literal();
	endtask

	task automatic test_trailing_backslash();
		literal_bytes = '{slu_pkg::CHAR_BACKSLASH};
		send_literal();
	endtask

	task automatic test_random_literals();
		while (bytes_sent < ITEM_TARGET) begin
			// Each literal draws whether either side idles at all, so long
			// stretches at full rate alternate with heavy idling.
			src_busy  = ($urandom_range(0, 3) != 0);
			sink_busy = ($urandom_range(0, 3) != 0);
			build_random_literal();
			send_literal();
			if (literals_sent % 150 == 0)
				wait_for_drain();
		end
	endtask

	initial begin : run
		bytes_if.valid   <= 1'b0;
		bytes_if.in_byte <= 8'h00;
		bytes_if.is_last <= 1'b0;
		arst_n           <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_bytes();
		test_escapes();
		test_raw_mode();
		test_utf8();
		test_trailing_backslash();
		// Let the block run completely dry before the random traffic starts.
		wait_for_drain();
		test_random_literals();

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d literals (%0d raw) in %0d bytes, %0d decoded; checked %0d results.",
			literals_sent, raw_literals, bytes_sent, bytes_decoded, results_checked);
		$display("Escape errors seen: %0d, UTF-8 errors seen: %0d, mismatches: %0d.",
			escape_errors, utf8_errors, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/slu_pkg.sv
src/slu_if.sv
src/slu_decode.sv
src/string_literal_unescaper.sv
bench/tb_string_literal_unescaper.sv
